// ----- rtl/sha512_pkg.sv -----
// SHA-512 engine package: types, round constants, initial hash values, helper functions.
// No dependencies.
`timescale 1ns / 1ps
package sha512_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_COMP,
        ST_FOLD,
        ST_EMIT
    } ctrl_state_t;

    // request from control to the compression core
    typedef struct packed {
        logic start;
        logic init;
    } core_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    function automatic logic [63:0] sha_init(input logic [2:0] idx);
        logic [63:0] r;
        unique case (idx)
            3'd0: r = 64'h6A09E667F3BCC908;
            3'd1: r = 64'hBB67AE8584CAA73B;
            3'd2: r = 64'h3C6EF372FE94F82B;
            3'd3: r = 64'hA54FF53A5F1D36F1;
            3'd4: r = 64'h510E527FADE682D1;
            3'd5: r = 64'h9B05688C2B3E6C1F;
            3'd6: r = 64'h1F83D9ABFB41BD6B;
            default: r = 64'h5BE0CD19137E2179;
        endcase
        return r;
    endfunction

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F,
        64'hE9B5DBA58189DBBC, 64'h3956C25BF348B538, 64'h59F111F1B605D019,
        64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118, 64'hD807AA98A3030242,
        64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235,
        64'hC19BF174CF692694, 64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3,
        64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65, 64'h2DE92C6F592B0275,
        64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F,
        64'hBF597FC7BEEF0EE4, 64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725,
        64'h06CA6351E003826F, 64'h142929670A0E6E70, 64'h27B70A8546D22FFC,
        64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6,
        64'h92722C851482353B, 64'hA2BFE8A14CF10364, 64'hA81A664BBC423001,
        64'hC24B8B70D0F89791, 64'hC76C51A30654BE30, 64'hD192E819D6EF5218,
        64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99,
        64'h34B0BCB5E19B48A8, 64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB,
        64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3, 64'h748F82EE5DEFB2FC,
        64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915,
        64'hC67178F2E372532B, 64'hCA273ECEEA26619C, 64'hD186B8C721C0C207,
        64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178, 64'h06F067AA72176FBA,
        64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC,
        64'h431D67C49C100D4C, 64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A,
        64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
    };

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

// ----- rtl/sha512_sched.sv -----
// SHA-512 message schedule: 16-word circular memory, read-modify-write per round.
// Depends on sha512_pkg.
`timescale 1ns / 1ps
module sha512_sched (
    input  logic        aclk,
    input  logic        load_en,
    input  logic [3:0]  load_addr,
    input  logic [63:0] load_data,
    input  logic        round_en,
    input  logic [6:0]  round_idx,
    output logic [63:0] w_out
);
    import sha512_pkg::*;

    logic [63:0] mem [16];
    logic [63:0] w_reg [16];
    logic [63:0] s0, s1, w_new, w15, w2, w7, w16;
    logic [3:0]  t4;

    // Buffer memory is the block store; a shadow copy holds the rolling schedule.
    always_ff @(posedge aclk) begin
        if (load_en) begin
            mem[load_addr] <= load_data;
        end
    end

    assign t4  = round_idx[3:0];
    assign w16 = w_reg[t4];
    assign w15 = w_reg[t4 + 4'd1];
    assign w7  = w_reg[t4 + 4'd9];
    assign w2  = w_reg[t4 + 4'd14];
    assign s0  = ror64(w15, 1) ^ ror64(w15, 8) ^ (w15 >> 7);
    assign s1  = ror64(w2, 19) ^ ror64(w2, 61) ^ (w2 >> 6);
    assign w_new = w16 + s0 + w7 + s1;

    always_ff @(posedge aclk) begin
        if (round_en && round_idx == 7'd0) begin
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= mem[i];
            end
        end else if (round_en && round_idx >= 7'd16) begin
            w_reg[t4] <= w_new;
        end
    end

    always_comb begin
        if (round_idx == 7'd0) begin
            w_out = mem[0];
        end else if (round_idx < 7'd16) begin
            w_out = w_reg[t4];
        end else begin
            w_out = w_new;
        end
    end
endmodule

// ----- rtl/sha512_core.sv -----
// SHA-512 round core: eight working registers, one round per cycle, chaining state memory.
// Depends on sha512_pkg and sha512_sched.
`timescale 1ns / 1ps
module sha512_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha512_pkg::core_req_t req,
    output sha512_pkg::core_stat_t stat,
    input  logic                  load_en,
    input  logic [3:0]            load_addr,
    input  logic [63:0]           load_data,
    input  logic [2:0]            rd_addr,
    output logic [63:0]           rd_data
);
    import sha512_pkg::*;

    logic [63:0] hmem [8];
    logic [7:0]  hvalid_reg;
    logic [63:0] v_reg [8];
    logic [6:0]  rnd_reg, rnd_next;
    logic        run_reg, fold_reg;
    logic [3:0]  fold_cnt_reg;
    logic [63:0] w_t, t1, t2, big0, big1, ch, maj, hval;
    logic [63:0] rd_data_reg;

    sha512_sched u_sched (
        .aclk     (aclk),
        .load_en  (load_en),
        .load_addr(load_addr),
        .load_data(load_data),
        .round_en (run_reg),
        .round_idx(rnd_reg),
        .w_out    (w_t)
    );

    assign big1 = ror64(v_reg[4], 14) ^ ror64(v_reg[4], 18) ^ ror64(v_reg[4], 41);
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + ROUND_K[rnd_reg] + w_t;
    assign big0 = ror64(v_reg[0], 28) ^ ror64(v_reg[0], 34) ^ ror64(v_reg[0], 39);
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;
    assign rnd_next = rnd_reg + 7'd1;

    function automatic logic [63:0] hread(input logic [2:0] a, input logic [7:0] vld,
                                          input logic [63:0] m);
        return vld[a] ? m : sha_init(a);
    endfunction

    assign hval = hread(fold_cnt_reg[2:0], hvalid_reg, hmem[fold_cnt_reg[2:0]]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg      <= 1'b0;
            fold_reg     <= 1'b0;
            rnd_reg      <= '0;
            fold_cnt_reg <= '0;
            hvalid_reg   <= '0;
        end else begin
            if (req.init) begin
                hvalid_reg <= '0;
            end
            if (req.start) begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
                for (int i = 0; i < 8; i++) begin
                    v_reg[i] <= hread(3'(i), hvalid_reg, hmem[i]);
                end
            end else if (run_reg) begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                rnd_reg  <= rnd_next;
                if (rnd_reg == 7'd79) begin
                    run_reg      <= 1'b0;
                    fold_reg     <= 1'b1;
                    fold_cnt_reg <= '0;
                end
            end else if (fold_reg) begin
                // fold one chaining word per cycle
                hmem[fold_cnt_reg[2:0]]       <= hval + v_reg[fold_cnt_reg[2:0]];
                hvalid_reg[fold_cnt_reg[2:0]] <= 1'b1;
                fold_cnt_reg <= fold_cnt_reg + 4'd1;
                if (fold_cnt_reg == 4'd7) begin
                    fold_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= hread(rd_addr, hvalid_reg, hmem[rd_addr]);
    end
    assign rd_data = rd_data_reg;

    // busy comes from registers only, so the input handshake never loops through start
    assign stat = {run_reg | fold_reg, fold_reg && fold_cnt_reg == 4'd7};
endmodule

// ----- rtl/sha512_hash_engine_top.sv -----
// SHA-512 engine top: input framing, padding, length words, digest output.
// Depends on sha512_pkg and sha512_core.
// Input: s_tready is low outside idle and while a block is in its rounds or its fold.
// Last word: padding and length take up to 18 words plus one or two blocks, then 0 to 8
// digest words are read from chaining memory and emitted.
// Reset: synchronous active-low aresetn reloads initial hash, output_bytes to 64.
`timescale 1ns / 1ps
module sha512_hash_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // data_word[63:0], byte_count[67:64], zero[71:68]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // digest_word[63:0], valid_bytes[67:64], zero[71:68]
    output logic        m_tlast
);
    import sha512_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [6:0]  outb_reg;
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] mbytes_reg, mbytes_next;
    logic [3:0]  emit_cnt_reg, emit_cnt_next;
    logic [6:0]  nbytes;
    logic [3:0]  nwords;
    logic        acc, push, pad_first_reg, pad_first_next;
    logic [63:0] push_data;
    logic [3:0]  bc;
    logic [63:0] keep, padword_reg, padword_next;
    core_req_t   req;
    core_stat_t  stat;
    logic [63:0] rd_data;
    logic        m_valid_reg;
    logic [63:0] m_word_reg;
    logic [3:0]  m_vb_reg;
    logic        m_last_reg, rd_pend_reg;
    logic [3:0]  vb;
    logic [6:0]  rem;

    sha512_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .stat     (stat),
        .load_en  (push),
        .load_addr(pos_reg),
        .load_data(push_data),
        .rd_addr  (emit_cnt_reg[2:0]),
        .rd_data  (rd_data)
    );

    assign nbytes = (outb_reg > 7'd64) ? 7'd64 : outb_reg;
    assign nwords = 4'((nbytes + 7'd7) >> 3);
    assign bc     = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
    assign keep   = (bc == 4'd0) ? 64'd0 : (~64'd0 << (7'(64) - {bc, 3'b000}));
    assign s_tready = (state_reg == ST_IDLE) && !stat.busy;
    assign acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            outb_reg       <= 7'd64;
            pos_reg        <= '0;
            mbytes_reg     <= '0;
            emit_cnt_reg   <= '0;
            pad_first_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            mbytes_reg     <= mbytes_next;
            emit_cnt_reg   <= emit_cnt_next;
            pad_first_reg  <= pad_first_next;
            if (cfg_wr_en) begin
                outb_reg <= cfg_wr_data;
            end
        end
        padword_reg <= padword_next;
    end

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        mbytes_next     = mbytes_reg;
        emit_cnt_next   = emit_cnt_reg;
        pad_first_next  = pad_first_reg;
        padword_next    = padword_reg;
        push            = 1'b0;
        push_data       = s_tdata[63:0];
        req.start       = 1'b0;
        req.init        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (!s_tlast) begin
                        mbytes_next = mbytes_reg + 64'd8;
                        push = 1'b1;
                    end else begin
                        mbytes_next = mbytes_reg + 64'(bc);
                        if (bc == 4'd8) begin
                            push = 1'b1;
                            padword_next = 64'h8000_0000_0000_0000;
                        end else begin
                            padword_next = (s_tdata[63:0] & keep)
                                | (64'h80 << (7'(56) - {bc, 3'b000}));
                        end
                        pad_first_next = 1'b1;
                        state_next = ST_PAD;
                    end
                    if (push) begin
                        pos_next = pos_reg + 4'd1;
                        if (pos_reg == 4'd15) begin
                            req.start = 1'b1;
                        end
                    end
                end
            end
            ST_PAD: begin
                // wait for any running block, then write padword or zeros through word 13
                if (!stat.busy) begin
                    push = 1'b1;
                    push_data = pad_first_reg ? padword_reg : 64'd0;
                    pad_first_next = 1'b0;
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd15) begin
                        req.start = 1'b1;
                    end else if (pos_reg == 4'd13) begin
                        state_next = ST_LEN_HI;
                    end
                end
            end
            ST_LEN_HI: begin
                push = 1'b1;
                push_data = {61'd0, mbytes_reg[63:61]};
                pos_next = pos_reg + 4'd1;
                state_next = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                push = 1'b1;
                push_data = {mbytes_reg[60:0], 3'b000};
                pos_next = '0;
                req.start = 1'b1;
                state_next = ST_COMP;
            end
            ST_COMP: begin
                if (stat.done) begin
                    emit_cnt_next = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_cnt_reg >= nwords && !m_valid_reg && !rd_pend_reg) begin
                    req.init = 1'b1;
                    mbytes_next = '0;
                    state_next = ST_IDLE;
                end else if (emit_cnt_reg < nwords && !rd_pend_reg
                             && (!m_valid_reg || m_tready)) begin
                    emit_cnt_next = emit_cnt_reg + 4'd1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registered read of chaining memory feeds the output register
    assign rem = nbytes - {emit_cnt_reg - 4'd1, 3'b000};
    assign vb  = (rem > 7'd8) ? 4'd8 : rem[3:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= (state_reg == ST_EMIT) && (emit_cnt_next != emit_cnt_reg);
            if (rd_pend_reg) begin
                m_valid_reg <= 1'b1;
                m_word_reg  <= (vb == 4'd8) ? rd_data
                             : rd_data & (~64'd0 << (7'(64) - {vb, 3'b000}));
                m_vb_reg    <= vb;
                m_last_reg  <= (emit_cnt_reg == nwords);
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_vb_reg, m_word_reg};
    assign m_tlast  = m_last_reg;
endmodule

// ----- rtl/sha512_checker.sv -----
// Port-level checker for the SHA-512 engine, bound to the top level.
// Depends on sha512_hash_engine_top.
`timescale 1ns / 1ps
module sha512_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output dropped under stall");
    a_vb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[67:64] <= 4'd8 && m_tdata[67:64] != 4'd0)
        else $error("bad valid byte count");
    a_part: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[67:64] != 4'd8 |-> m_tlast)
        else $error("partial digest word not last");
    a_noin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken during digest output");
endmodule

bind sha512_hash_engine_top sha512_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
